// ----- design/triangle_tangent_unit_core_assert.svh -----
// Assertion macros shared by the triangle tangent unit modules.
// Depends on nothing; the users supply i_clk and i_rst_n in their scope.
`ifndef TRIANGLE_TANGENT_UNIT_CORE_ASSERT_SVH
`define TRIANGLE_TANGENT_UNIT_CORE_ASSERT_SVH
`ifndef SYNTH
`define TTU_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tangent unit assertion failed");
`define TTU_ASSERT(lbl, prop) `TTU_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)
`else
`define TTU_ASSERT_CLK(lbl, clk, rst_n, prop)
`define TTU_ASSERT(lbl, prop)
`endif
`endif

// ----- design/tantu_pkg.sv -----
// Shared constants and types of the triangle tangent unit.
// Depends on nothing.
package tantu_pkg;
    localparam int POSITION_WIDTH_DEF        = 32;
    localparam int UV_WIDTH_DEF              = 20;
    localparam int TANGENT_FRACTION_BITS_DEF = 14;
    // Magnitudes are brought below this many bits before normalization.
    localparam int MAG_BITS                  = 31;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DET = 2'd1,
        ST_ZERO_LEN = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        C_FIRST  = 2'd0,
        C_SECOND = 2'd1,
        C_THIRD  = 2'd2
    } t_corner;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_CHECK, S_NORM, S_SQR, S_SQRT, S_DLOAD, S_DIV, S_DONE
    } t_back_state;
endpackage

// ----- design/tantu_front.sv -----
// Front end: takes vertices, holds the first two corners and forms the
// edge and UV deltas of each triangle. Depends on tantu_pkg.
module tantu_front import tantu_pkg::*; #(
    parameter int PW = POSITION_WIDTH_DEF,
    parameter int UW = UV_WIDTH_DEF,
    parameter int QW = 4 * (UW + 1) + 6 * (PW + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [PW-1:0] i_px,
    input  logic signed [PW-1:0] i_py,
    input  logic signed [PW-1:0] i_pz,
    input  logic signed [UW-1:0] i_u,
    input  logic signed [UW-1:0] i_v,
    output logic                 o_push_valid,
    input  logic                 i_push_ready,
    output logic [QW-1:0]        o_data
);
    localparam int EW = PW + 1;
    localparam int DW = UW + 1;

    t_corner r_corner, n_corner;
    logic signed [PW-1:0] r_p0 [3];
    logic signed [PW-1:0] r_p1 [3];
    logic signed [UW-1:0] r_uv0 [2];
    logic signed [UW-1:0] r_uv1 [2];
    logic accept;

    assign accept = i_valid && o_ready;
    // Only the third corner pushes a triangle, so only it waits for room in the queue.
    assign o_ready = (r_corner != C_THIRD) || i_push_ready;
    assign o_push_valid = accept && (r_corner == C_THIRD);

    always_comb begin
        n_corner = r_corner;
        if (accept) begin
            unique case (r_corner)
                C_FIRST:  n_corner = C_SECOND;
                C_SECOND: n_corner = C_THIRD;
                C_THIRD:  n_corner = C_FIRST;
                default:  n_corner = C_SECOND;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner <= C_FIRST;
        end else begin
            r_corner <= n_corner;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && r_corner != C_SECOND && r_corner != C_THIRD) begin
            r_p0[0] <= i_px; r_p0[1] <= i_py; r_p0[2] <= i_pz;
            r_uv0[0] <= i_u; r_uv0[1] <= i_v;
        end
        if (accept && r_corner == C_SECOND) begin
            r_p1[0] <= i_px; r_p1[1] <= i_py; r_p1[2] <= i_pz;
            r_uv1[0] <= i_u; r_uv1[1] <= i_v;
        end
    end

    logic signed [EW-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
    logic signed [DW-1:0] du1, dv1, du2, dv2;

    assign e1x = EW'(r_p1[0]) - EW'(r_p0[0]);
    assign e1y = EW'(r_p1[1]) - EW'(r_p0[1]);
    assign e1z = EW'(r_p1[2]) - EW'(r_p0[2]);
    assign e2x = EW'(i_px) - EW'(r_p0[0]);
    assign e2y = EW'(i_py) - EW'(r_p0[1]);
    assign e2z = EW'(i_pz) - EW'(r_p0[2]);
    assign du1 = DW'(r_uv1[0]) - DW'(r_uv0[0]);
    assign dv1 = DW'(r_uv1[1]) - DW'(r_uv0[1]);
    assign du2 = DW'(i_u) - DW'(r_uv0[0]);
    assign dv2 = DW'(i_v) - DW'(r_uv0[1]);

    assign o_data = {e2z, e2y, e2x, e1z, e1y, e1x, dv2, du2, dv1, du1};
endmodule

// ----- design/tantu_fifo.sv -----
// Two-entry queue of triangle deltas between front and back end.
// Depends on tantu_pkg.
module tantu_fifo import tantu_pkg::*; #(
    parameter int QW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  logic [QW-1:0] i_data,
    output logic          o_valid,
    input  logic          i_pop,
    output logic [QW-1:0] o_data
);
    logic [QW-1:0] r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          do_push, do_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_valid      = (r_cnt != 2'd0);
    assign do_push      = i_push_valid && o_push_ready;
    assign do_pop       = i_pop && o_valid;
    assign o_data       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 2'd1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end
endmodule

// ----- design/tantu_back.sv -----
// Back end: products, normalization, square root and division for one
// triangle at a time, with the output register. Depends on tantu_pkg.
module tantu_back import tantu_pkg::*; #(
    parameter int PW = POSITION_WIDTH_DEF,
    parameter int UW = UV_WIDTH_DEF,
    parameter int F  = TANGENT_FRACTION_BITS_DEF,
    parameter int QW = 4 * (UW + 1) + 6 * (PW + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_pop,
    input  logic [QW-1:0]       i_data,
    output logic                o_tvalid,
    input  logic                i_tready,
    output logic signed [F+1:0] o_tx,
    output logic signed [F+1:0] o_ty,
    output logic signed [F+1:0] o_tz,
    output t_status             o_status
);
`include "triangle_tangent_unit_core_assert.svh"
    localparam int DW  = UW + 1;
    localparam int EW  = PW + 1;
    localparam int MW  = (EW > DW) ? EW : DW;
    localparam int SW  = 2 * MW + 1;
    localparam int TW  = F + 2;
    localparam int NSW = MAG_BITS + 1;
    localparam int DVW = NSW + 1;
    localparam int SQW = 2 * MAG_BITS + 2;
    localparam int NW  = MAG_BITS + F + 2;
    localparam int NCW = $clog2(NW + 1);
    localparam int SQRT_STEPS = SQW / 2;

    t_back_state r_state, n_state;
    logic [QW-1:0]        r_in;
    logic [3:0]           r_step;
    logic signed [2*MW-1:0] r_prod, r_acc;
    logic signed [SW-1:0] r_det;
    logic signed [SW-1:0] r_r [3];
    logic [SW-1:0]        r_mag [3];
    logic                 r_rneg [3];
    logic                 r_dneg;
    logic [1:0]           r_j;
    logic [SQW-1:0]       r_sum, r_x, r_res, r_bit;
    logic [NSW-1:0]       r_n;
    logic [NW-1:0]        r_num, r_quo;
    logic [DVW-1:0]       r_rem;
    logic [NCW-1:0]       r_cnt;
    logic signed [TW-1:0] r_tan [3];
    t_status              r_status;
    logic                 r_ov;
    logic signed [TW-1:0] r_ox, r_oy, r_oz;
    t_status              r_ost;

    logic signed [DW-1:0] du1, dv1, du2, dv2;
    logic signed [EW-1:0] e1 [3];
    logic signed [EW-1:0] e2 [3];
    assign {e2[2], e2[1], e2[0], e1[2], e1[1], e1[0], dv2, du2, dv1, du1} = r_in;

    logic signed [MW-1:0]   op_a, op_b;
    logic signed [2*MW-1:0] mul;
    always_comb begin
        case (r_step[2:0])
            3'd0:    begin op_a = MW'(du1); op_b = MW'(dv2);   end
            3'd1:    begin op_a = MW'(du2); op_b = MW'(dv1);   end
            3'd2:    begin op_a = MW'(dv2); op_b = MW'(e1[0]); end
            3'd3:    begin op_a = MW'(dv1); op_b = MW'(e2[0]); end
            3'd4:    begin op_a = MW'(dv2); op_b = MW'(e1[1]); end
            3'd5:    begin op_a = MW'(dv1); op_b = MW'(e2[1]); end
            3'd6:    begin op_a = MW'(dv2); op_b = MW'(e1[2]); end
            default: begin op_a = MW'(dv1); op_b = MW'(e2[2]); end
        endcase
    end
    assign mul = op_a * op_b;

    logic signed [SW-1:0] diff;
    assign diff = SW'(r_acc) - SW'(r_prod);

    logic over;
    logic [SW-1:0] mag_or;
    assign mag_or = r_mag[0] | r_mag[1] | r_mag[2];
    assign over   = |(mag_or >> MAG_BITS);

    logic [MAG_BITS-1:0]   sq_in;
    logic [2*MAG_BITS-1:0] sq;
    assign sq_in = r_mag[r_j][MAG_BITS-1:0];
    assign sq    = sq_in * sq_in;

    logic [SQW-1:0] trial;
    logic           take;
    assign trial = r_res + r_bit;
    assign take  = (r_x >= trial);

    // One restoring division step per cycle.
    logic [DVW:0]   rem_sh, rem_nx;
    logic [DVW-1:0] dvs;
    logic           ge;
    logic [NW-1:0]  quo_nx;
    logic [TW-1:0]  q_sat;
    logic           last_div;
    assign dvs     = {r_n, 1'b0};
    assign rem_sh  = {r_rem, r_num[NW-1]};
    assign ge      = (rem_sh >= (DVW + 1)'(dvs));
    assign rem_nx  = ge ? (rem_sh - (DVW + 1)'(dvs)) : rem_sh;
    assign quo_nx  = {r_quo[NW-2:0], ge};
    assign q_sat   = (quo_nx > (NW'(1) << F)) ? (TW'(1) << F) : quo_nx[TW-1:0];
    assign last_div = (r_cnt == NCW'(1));

    logic out_free;
    assign out_free = !r_ov || i_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_MUL;
            S_MUL:   if (r_step == 4'd8) n_state = S_CHECK;
            S_CHECK: begin
                if (r_det == '0 || (r_r[0] == '0 && r_r[1] == '0 && r_r[2] == '0))
                    n_state = S_DONE;
                else
                    n_state = S_NORM;
            end
            S_NORM:  if (!over) n_state = S_SQR;
            S_SQR:   if (r_j == 2'd2) n_state = S_SQRT;
            S_SQRT:  if (r_cnt == NCW'(1)) n_state = S_DLOAD;
            S_DLOAD: n_state = S_DIV;
            S_DIV:   if (last_div) n_state = (r_j == 2'd2) ? S_DONE : S_DLOAD;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop = (r_state == S_IDLE) && i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) r_ov <= 1'b1;
            else if (i_tready)                 r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_in   <= i_data;
                r_step <= 4'd0;
            end
            S_MUL: begin
                r_step <= r_step + 4'd1;
                r_prod <= mul;
                if (r_step[0]) begin
                    r_acc <= r_prod;
                end else if (r_step == 4'd2) begin
                    r_det <= diff;
                end else if (r_step == 4'd4) begin
                    r_r[0] <= diff;
                end else if (r_step == 4'd6) begin
                    r_r[1] <= diff;
                end else if (r_step == 4'd8) begin
                    r_r[2] <= diff;
                end
            end
            S_CHECK: begin
                for (int i = 0; i < 3; i++) begin
                    r_tan[i]  <= '0;
                    r_rneg[i] <= r_r[i][SW-1];
                    r_mag[i]  <= r_r[i][SW-1] ? (SW'(0) - r_r[i]) : r_r[i];
                end
                r_dneg <= r_det[SW-1];
                r_j    <= 2'd0;
                r_sum  <= '0;
                if (r_det == '0)
                    r_status <= ST_ZERO_DET;
                else if (r_r[0] == '0 && r_r[1] == '0 && r_r[2] == '0)
                    r_status <= ST_ZERO_LEN;
                else
                    r_status <= ST_OK;
            end
            S_NORM: begin
                if (over) begin
                    for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                end
            end
            S_SQR: begin
                r_j   <= (r_j == 2'd2) ? 2'd0 : r_j + 2'd1;
                r_x   <= r_sum + SQW'(sq);
                r_sum <= r_sum + SQW'(sq);
                r_res <= '0;
                r_bit <= SQW'(1) << (SQW - 2);
                r_cnt <= NCW'(SQRT_STEPS);
            end
            S_SQRT: begin
                if (take) begin
                    r_x   <= r_x - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - NCW'(1);
            end
            S_DLOAD: begin
                // A root of zero is replaced by one, so the divisor is never zero.
                if (r_n == '0) r_n <= NSW'(1);
                r_num <= NW'({r_mag[r_j][MAG_BITS-1:0], {(F + 1){1'b0}}})
                         + NW'((r_n == '0) ? NSW'(1) : r_n);
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= NCW'(NW);
            end
            S_DIV: begin
                r_rem <= rem_nx[DVW-1:0];
                r_num <= r_num << 1;
                r_quo <= quo_nx;
                r_cnt <= r_cnt - NCW'(1);
                if (last_div) begin
                    r_tan[r_j] <= (r_rneg[r_j] != r_dneg) ? (TW'(0) - q_sat) : q_sat;
                    r_j <= r_j + 2'd1;
                end
            end
            default: begin
            end
        endcase
        // The root leaves the sequencer on its last step.
        if (r_state == S_SQRT && r_cnt == NCW'(1))
            r_n <= take ? NSW'((r_res >> 1) + r_bit) : NSW'(r_res >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_ox  <= r_tan[0];
            r_oy  <= r_tan[1];
            r_oz  <= r_tan[2];
            r_ost <= r_status;
        end
    end

    assign o_tvalid = r_ov;
    assign o_tx     = r_ox;
    assign o_ty     = r_oy;
    assign o_tz     = r_oz;
    assign o_status = r_ost;

    `TTU_ASSERT(a_err_zero, (r_ov && r_ost != ST_OK) |-> (r_ox == '0 && r_oy == '0 && r_oz == '0))
    `TTU_ASSERT(a_done_loads, (r_state == S_DONE && out_free) |=> r_ov)
    `TTU_ASSERT(a_norm_fits, (r_state == S_SQR) |-> !over)
    `TTU_ASSERT(a_pop_idle, o_pop |=> (r_state == S_MUL && r_step == 4'd0))
endmodule

// ----- design/triangle_tangent_unit_core.sv -----
// Triangle tangent unit: per-triangle unit tangent for normal mapping.
// Vertices enter on the slave stream, one per request, three per triangle.
// tdata, lowest bit first: position_x, position_y, position_z, tex_u, tex_v.
// The master stream returns one result per triangle, after its third vertex:
// tdata holds tangent_x, tangent_y, tangent_z (Q1.14 at default), tuser the
// status (0 ok, 1 zero UV determinant, 2 zero-length tangent).
// The first two vertices of a triangle are always taken; the third
// is taken when the two-entry triangle queue has room.
// The back end works on one triangle at a time: it takes it from the queue,
// forms the products on one shared multiplier, checks them, normalizes by
// shifting one bit at a time while the largest raw component is wider than 31
// bits (at most UV_WIDTH+POSITION_WIDTH+2-31 shifts), forms 3 squares, runs 32
// square-root steps, divides in three runs of NW steps, with NW =
// 33+TANGENT_FRACTION_BITS, and loads the output register; a zero determinant
// or tangent goes straight to the output. Division takes most of the time.
// Reset (synchronous, active low) empties the queue, drops the corner count and idles the back end.
// While the receiver stalls, the result holds in the output register, the back
// end waits with the next one finished, and the queue fills before the input
// stalls on a third vertex.
module triangle_tangent_unit_core import tantu_pkg::*; #(
    parameter int POSITION_WIDTH        = POSITION_WIDTH_DEF,
    parameter int UV_WIDTH              = UV_WIDTH_DEF,
    parameter int TANGENT_FRACTION_BITS = TANGENT_FRACTION_BITS_DEF,
    parameter int IW = ((3 * POSITION_WIDTH + 2 * UV_WIDTH + 7) / 8) * 8,
    parameter int OW = ((3 * (TANGENT_FRACTION_BITS + 2) + 7) / 8) * 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // position_x, position_y, position_z, tex_u, tex_v
    input  logic [IW-1:0] i_s_axis_tdata,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // tangent_x, tangent_y, tangent_z
    output logic [OW-1:0] o_m_axis_tdata,
    // status
    output logic [1:0]    o_m_axis_tuser
);
    localparam int PW = POSITION_WIDTH;
    localparam int UW = UV_WIDTH;
    localparam int F  = TANGENT_FRACTION_BITS;
    localparam int TW = F + 2;
    localparam int QW = 4 * (UW + 1) + 6 * (PW + 1);

    logic signed [PW-1:0] px, py, pz;
    logic signed [UW-1:0] tu, tv;
    assign px = i_s_axis_tdata[PW-1:0];
    assign py = i_s_axis_tdata[2*PW-1:PW];
    assign pz = i_s_axis_tdata[3*PW-1:2*PW];
    assign tu = i_s_axis_tdata[3*PW+UW-1:3*PW];
    assign tv = i_s_axis_tdata[3*PW+2*UW-1:3*PW+UW];

    logic          push_valid, push_ready;
    logic [QW-1:0] push_data, pop_data;
    logic          q_valid, q_pop;

    tantu_front #(.PW(PW), .UW(UW), .QW(QW)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_px         (px),
        .i_py         (py),
        .i_pz         (pz),
        .i_u          (tu),
        .i_v          (tv),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_data       (push_data)
    );

    tantu_fifo #(.QW(QW)) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_data       (push_data),
        .o_valid      (q_valid),
        .i_pop        (q_pop),
        .o_data       (pop_data)
    );

    logic signed [TW-1:0] tx, ty, tz;
    t_status              st;

    tantu_back #(.PW(PW), .UW(UW), .F(F), .QW(QW)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .o_pop    (q_pop),
        .i_data   (pop_data),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tx     (tx),
        .o_ty     (ty),
        .o_tz     (tz),
        .o_status (st)
    );

    assign o_m_axis_tdata = OW'({tz, ty, tx});
    assign o_m_axis_tuser = st;
endmodule
